[hdl/token_scanner_unit_macros.svh]
// Assertion macros for the token scanner unit.
`ifndef TOKEN_SCANNER_UNIT_MACROS_SVH
`define TOKEN_SCANNER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TSU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/tsu_pkg.sv]
// Shared types, codes and character helpers of the token scanner.
`timescale 1ns / 1ps
package tsu_pkg;

  localparam int COUNTER_BITS_DEF = 16;
  localparam int FIFO_DEPTH       = 4;
  localparam int FIFO_PTR_W       = 2;
  localparam int FIFO_CNT_W       = 3;

  // scanner states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_IDENT  = 3'd1;
  localparam logic [2:0] ST_INT    = 3'd2;
  localparam logic [2:0] ST_DOT    = 3'd3;
  localparam logic [2:0] ST_FRAC   = 3'd4;
  localparam logic [2:0] ST_STRING = 3'd5;
  localparam logic [2:0] ST_OP     = 3'd6;

  // pending two-byte operator
  localparam logic [1:0] OP_LT   = 2'd0;
  localparam logic [1:0] OP_GT   = 2'd1;
  localparam logic [1:0] OP_EQ   = 2'd2;
  localparam logic [1:0] OP_BANG = 2'd3;

  // token classes
  localparam logic [3:0] CL_IDENT  = 4'd0;
  localparam logic [3:0] CL_INT    = 4'd1;
  localparam logic [3:0] CL_FLOAT  = 4'd2;
  localparam logic [3:0] CL_STRING = 4'd3;
  localparam logic [3:0] CL_ARITH  = 4'd4;
  localparam logic [3:0] CL_REL    = 4'd5;
  localparam logic [3:0] CL_LPAREN = 4'd6;
  localparam logic [3:0] CL_RPAREN = 4'd7;
  localparam logic [3:0] CL_LBRACK = 4'd8;
  localparam logic [3:0] CL_RBRACK = 4'd9;
  localparam logic [3:0] CL_LBRACE = 4'd10;
  localparam logic [3:0] CL_RBRACE = 4'd11;
  localparam logic [3:0] CL_COMMA  = 4'd12;
  localparam logic [3:0] CL_SEMI   = 4'd13;
  localparam logic [3:0] CL_EQUAL  = 4'd14;
  localparam logic [3:0] CL_ERROR  = 4'd15;

  typedef struct packed {
    logic [3:0]  cls;
    logic [15:0] line;
    logic [15:0] col;
    logic [15:0] len;
    logic        last;
  } tsu_rec_t;

  // records produced by one accepted byte
  typedef struct packed {
    logic [1:0] cnt;
    tsu_rec_t   rec0;
    tsu_rec_t   rec1;
  } tsu_push_t;

  typedef struct packed {
    logic       vld;
    logic       err;
    logic [3:0] cls;
  } tsu_close_t;

  typedef struct packed {
    logic       emit;
    logic       err;
    logic [3:0] cls;
    logic [2:0] st;
    logic [1:0] op;
  } tsu_start_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // What an open token turns into when something ends it.
  function automatic tsu_close_t close_fn(input logic [2:0] st, input logic [1:0] op);
    tsu_close_t r;
    r = '0;
    unique case (st)
      ST_IDENT:        begin r.vld = 1'b1; r.cls = CL_IDENT; end
      ST_INT:          begin r.vld = 1'b1; r.cls = CL_INT; end
      ST_DOT, ST_FRAC: begin r.vld = 1'b1; r.cls = CL_FLOAT; end
      ST_STRING:       begin r.vld = 1'b1; r.err = 1'b1; r.cls = CL_ERROR; end
      ST_OP: begin
        r.vld = 1'b1;
        unique case (op)
          OP_BANG: begin r.err = 1'b1; r.cls = CL_ERROR; end
          OP_EQ:   r.cls = CL_EQUAL;
          default: r.cls = CL_REL;
        endcase
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // Classify the first byte of a token.
  function automatic tsu_start_t start_fn(input logic [7:0] c);
    tsu_start_t s;
    s = '0;
    s.st = ST_IDLE;
    priority if (is_space(c)) begin
      s.emit = 1'b0;
    end else if (is_letter(c)) begin
      s.st = ST_IDENT;
    end else if (is_digit(c)) begin
      s.st = ST_INT;
    end else begin
      s.emit = 1'b1;
      unique case (c)
        "\"": begin s.emit = 1'b0; s.st = ST_STRING; end
        "+", "-", "*", "/", "%": s.cls = CL_ARITH;
        "<": begin s.emit = 1'b0; s.st = ST_OP; s.op = OP_LT; end
        ">": begin s.emit = 1'b0; s.st = ST_OP; s.op = OP_GT; end
        "=": begin s.emit = 1'b0; s.st = ST_OP; s.op = OP_EQ; end
        "!": begin s.emit = 1'b0; s.st = ST_OP; s.op = OP_BANG; end
        "(": s.cls = CL_LPAREN;
        ")": s.cls = CL_RPAREN;
        "[": s.cls = CL_LBRACK;
        "]": s.cls = CL_RBRACK;
        "{": s.cls = CL_LBRACE;
        "}": s.cls = CL_RBRACE;
        ",": s.cls = CL_COMMA;
        ";": s.cls = CL_SEMI;
        default: begin s.err = 1'b1; s.cls = CL_ERROR; end
      endcase
    end
    return s;
  endfunction

endpackage

[hdl/tsu_if.sv]
// Valid/ready channel interfaces for source bytes and token records.
`timescale 1ns / 1ps
interface tsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_text;
  modport source (output valid, ch, end_of_text, input ready);
  modport sink   (input valid, ch, end_of_text, output ready);
endinterface

interface tsu_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_class;
  logic [15:0] start_line;
  logic [15:0] start_column;
  logic [15:0] token_length;
  logic        last_of_run;
  modport source (output valid, token_class, start_line, start_column, token_length,
                  last_of_run, input ready);
  modport sink   (input valid, token_class, start_line, start_column, token_length,
                  last_of_run, output ready);
endinterface

[hdl/tsu_scan_core.sv]
// Scanner state registers and the one-byte transition logic.
`timescale 1ns / 1ps
module tsu_scan_core import tsu_pkg::*; #(
  parameter int CounterBits = COUNTER_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  logic [7:0] ch_i,
  input  logic      eot_i,
  output tsu_push_t push_o
);

  localparam int CmpW = (CounterBits > 16) ? CounterBits : 16;
  localparam logic [CounterBits-1:0] One = CounterBits'(1);

  logic [2:0]             st_q, st_d;
  logic [1:0]             op_q, op_d;
  logic [CounterBits-1:0] cl_q, cl_d, cc_q, cc_d;
  logic [CounterBits-1:0] tl_q, tl_d, tc_q, tc_d, len_q, len_d;
  logic                   halt_q, halt_d;

  function automatic logic [CounterBits-1:0] sat_inc(input logic [CounterBits-1:0] v);
    return (&v) ? v : v + One;
  endfunction

  function automatic logic [15:0] clamp16(input logic [CounterBits-1:0] v);
    logic [CmpW-1:0] ve;
    ve = CmpW'(v);
    return (ve > CmpW'(16'hFFFF)) ? 16'hFFFF : ve[15:0];
  endfunction

  function automatic tsu_rec_t mk_rec(input logic [3:0] cls, input logic [CounterBits-1:0] line,
                                      input logic [CounterBits-1:0] col,
                                      input logic [CounterBits-1:0] len, input logic err);
    tsu_rec_t r;
    r.cls  = cls;
    r.line = clamp16(line);
    r.col  = clamp16(col);
    r.len  = err ? 16'd0 : clamp16(len);
    r.last = 1'b0;
    return r;
  endfunction

  logic                   take, a_vld, a_err, b_vld, b_err, c_vld, err_m;
  logic [3:0]             a_cls;
  logic [2:0]             st_m;
  logic [1:0]             op_m;
  logic [CounterBits-1:0] tl_m, tc_m, len_m;
  tsu_close_t             cp, cf;
  tsu_start_t             sc;
  tsu_rec_t               rec_a, rec_b, rec_c;

  always_comb begin
    st_d   = st_q;
    op_d   = op_q;
    cl_d   = cl_q;
    cc_d   = cc_q;
    tl_d   = tl_q;
    tc_d   = tc_q;
    len_d  = len_q;
    halt_d = halt_q;
    take   = 1'b0;
    a_vld  = 1'b0;
    a_err  = 1'b0;
    a_cls  = CL_STRING;
    b_vld  = 1'b0;
    b_err  = 1'b0;
    c_vld  = 1'b0;
    st_m   = st_q;
    op_m   = op_q;
    tl_m   = tl_q;
    tc_m   = tc_q;
    len_m  = len_q;
    cp     = '0;
    cf     = '0;
    sc     = '0;
    err_m  = 1'b0;

    // first try to extend or finish the open token
    unique case (st_q)
      ST_IDENT: take = is_letter(ch_i) || is_digit(ch_i);
      ST_INT: begin
        if (is_digit(ch_i)) begin
          take = 1'b1;
        end else if (ch_i == ".") begin
          take = 1'b1;
          st_m = ST_DOT;
        end
      end
      ST_DOT, ST_FRAC: begin
        if (is_digit(ch_i)) begin
          take = 1'b1;
          st_m = ST_FRAC;
        end
      end
      ST_STRING: begin
        take = 1'b1;
        if (ch_i == "\"") begin
          a_vld = 1'b1;
          a_cls = CL_STRING;
          st_m  = ST_IDLE;
        end
      end
      ST_OP: begin
        if (ch_i == "=") begin
          take  = 1'b1;
          a_vld = 1'b1;
          a_cls = CL_REL;
          st_m  = ST_IDLE;
        end
      end
      default: take = 1'b0;
    endcase

    if (take) begin
      len_m = sat_inc(len_q);
    end else begin
      // close what was open, then, unless that close is an error, scan the byte as a new token
      cp    = close_fn(st_q, op_q);
      a_vld = cp.vld;
      a_err = cp.err;
      a_cls = cp.cls;
      st_m  = ST_IDLE;
      if (!cp.err) begin
        sc    = start_fn(ch_i);
        tl_m  = cl_q;
        tc_m  = cc_q;
        len_m = One;
        st_m  = sc.st;
        if (sc.st == ST_OP) begin
          op_m = sc.op;
        end
        b_vld = sc.emit;
        b_err = sc.err;
      end
    end
    err_m = a_err | b_err;

    if (eot_i && !err_m) begin
      cf    = close_fn(st_m, op_m);
      c_vld = cf.vld;
    end

    if (accept_i) begin
      if (halt_q || eot_i) begin
        if (eot_i) begin
          st_d   = ST_IDLE;
          op_d   = OP_LT;
          cl_d   = One;
          cc_d   = One;
          tl_d   = One;
          tc_d   = One;
          len_d  = '0;
          halt_d = 1'b0;
        end
      end else begin
        st_d   = st_m;
        op_d   = op_m;
        tl_d   = tl_m;
        tc_d   = tc_m;
        len_d  = len_m;
        halt_d = err_m;
        if (ch_i == 8'd10) begin
          cl_d = sat_inc(cl_q);
          cc_d = One;
        end else begin
          cc_d = sat_inc(cc_q);
        end
      end
    end
  end

  // record a comes from the open token, b from a one-byte token, c from end of text
  assign rec_a = mk_rec(a_cls, tl_q, tc_q, take ? len_m : len_q, a_err);
  assign rec_b = mk_rec(sc.cls, cl_q, cc_q, One, b_err);
  assign rec_c = mk_rec(cf.cls, tl_m, tc_m, len_m, cf.err);

  logic a_on, b_on, c_on;
  assign a_on = accept_i && !halt_q && a_vld;
  assign b_on = accept_i && !halt_q && b_vld;
  assign c_on = accept_i && !halt_q && c_vld;

  always_comb begin
    push_o.cnt  = 2'(a_on) + 2'(b_on) + 2'(c_on);
    push_o.rec0 = a_on ? rec_a : (b_on ? rec_b : rec_c);
    push_o.rec1 = (a_on && b_on) ? rec_b : rec_c;
    push_o.rec0.last = (push_o.cnt == 2'd1);
    push_o.rec1.last = (push_o.cnt == 2'd2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      op_q   <= OP_LT;
      cl_q   <= One;
      cc_q   <= One;
      tl_q   <= One;
      tc_q   <= One;
      len_q  <= '0;
      halt_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      op_q   <= op_d;
      cl_q   <= cl_d;
      cc_q   <= cc_d;
      tl_q   <= tl_d;
      tc_q   <= tc_d;
      len_q  <= len_d;
      halt_q <= halt_d;
    end
  end

endmodule

[hdl/tsu_rec_fifo.sv]
// Four-entry record queue between the scanner and the token channel.
`timescale 1ns / 1ps
module tsu_rec_fifo import tsu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tsu_push_t        push_i,
  output logic             ready_o,
  tsu_out_if.source        out_o
);

  tsu_rec_t              mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [FIFO_CNT_W-1:0] fill_q, fill_d;
  logic                  pop;
  tsu_rec_t              head;

  // room for the worst case of two records from one byte
  assign ready_o = fill_q <= FIFO_CNT_W'(FIFO_DEPTH - 2);

  assign head              = mem_q[rp_q];
  assign out_o.valid        = fill_q != '0;
  assign out_o.token_class  = head.cls;
  assign out_o.start_line   = head.line;
  assign out_o.start_column = head.col;
  assign out_o.token_length = head.len;
  assign out_o.last_of_run  = head.last;

  assign pop    = out_o.valid && out_o.ready;
  assign wp_d   = wp_q + FIFO_PTR_W'(push_i.cnt);
  assign rp_d   = rp_q + FIFO_PTR_W'(pop);
  assign fill_d = fill_q + FIFO_CNT_W'(push_i.cnt) - FIFO_CNT_W'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wp_q] <= push_i.rec0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wp_q + FIFO_PTR_W'(1)] <= push_i.rec1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      rp_q   <= '0;
      fill_q <= '0;
    end else begin
      wp_q   <= wp_d;
      rp_q   <= rp_d;
      fill_q <= fill_d;
    end
  end

endmodule

[hdl/token_scanner_unit.sv]
// Token scanner top level: byte channel in, token record channel out.
//
//   channel | dir | word                                   | handshake
//   in_i    | in  | ch, end_of_text                        | valid/ready
//   out_o   | out | token_class, start_line, start_column, | valid/ready
//           |     | token_length, last_of_run              |
//
// One byte is scanned per cycle while in_i.ready is high; its zero to two records
// land in a 4-entry queue at the same edge and leave one per cycle while
// out_o.ready is high. in_i.ready drops while the queue has fewer than two free
// entries. Reset is asynchronous: scanner back to line 1, column 1, queue empty.
// Nothing is lost or repeated when out_o stalls.
`timescale 1ns / 1ps
`include "token_scanner_unit_macros.svh"
module token_scanner_unit import tsu_pkg::*; #(
  parameter int CounterBits = COUNTER_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tsu_in_if.sink    in_i,
  tsu_out_if.source out_o
);

  logic      q_ready;
  logic      accept;
  tsu_push_t push;

  assign in_i.ready = q_ready;
  assign accept     = in_i.valid && q_ready;

  tsu_scan_core #(.CounterBits(CounterBits)) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .ch_i     (in_i.ch),
    .eot_i    (in_i.end_of_text),
    .push_o   (push)
  );

  tsu_rec_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ready_o (q_ready),
    .out_o   (out_o)
  );

  `TSU_ASSERT_NOW(a_push_needs_accept, !accept, push.cnt == 2'd0, "records without a byte")
  `TSU_ASSERT_NOW(a_two_last_marked, push.cnt == 2'd2, push.rec1.last && !push.rec0.last, "bad last flag")
  `TSU_ASSERT_NOW(a_error_len_zero, out_o.valid && out_o.token_class == CL_ERROR, out_o.token_length == 16'd0, "error length")

endmodule
